/* src/cholesky_decomposition_unit_assert.svh */
// assertion helpers for the cholesky unit
`ifndef CHOLESKY_DECOMPOSITION_UNIT_ASSERT_SVH
`define CHOLESKY_DECOMPOSITION_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CHOL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CHOL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/chol_pkg.sv */
package chol_pkg;

    localparam int MAX_SIZE = 8;
    localparam int IDX_W    = 3;
    localparam int SIZE_W   = 4;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int PADDR_W  = 3;

    localparam logic [PADDR_W-1:0] ADDR_MATRIX_SIZE = 3'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET       = 4'd8;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ACC,
        S_K0,
        S_KLOOP,
        S_KA,
        S_KB,
        S_KSUB,
        S_FIN,
        S_DIVGO,
        S_WAITU,
        S_ERD,
        S_EOUT,
        S_EERR
    } t_state;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

endpackage

/* src/chol_ram.sv */
module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/chol_divsqrt.sv */
module chol_divsqrt import chol_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_unit_req        i_req,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic             o_done,
    output logic [31:0]      o_result
);

    logic            r_busy, n_busy;
    t_unit_op        r_op, n_op;
    logic            r_neg, n_neg;
    logic [5:0]      r_cnt, n_cnt;
    logic [47:0]     r_x, n_x;
    logic [32:0]     r_rem, n_rem;
    logic [47:0]     r_q, n_q;
    logic [47:0]     r_bit, n_bit;
    logic [31:0]     r_b, n_b;
    logic            r_done, n_done;

    logic [31:0]     a_mag;
    logic [32:0]     rem_sh;
    logic [47:0]     trial;

    assign a_mag  = i_a[31] ? (~i_a + 32'd1) : i_a;
    assign rem_sh = {r_rem[31:0], r_x[47]};
    assign trial  = r_q + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_q    = r_q;
        n_bit  = r_bit;
        n_b    = r_b;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_neg  = i_a[31];
            n_rem  = '0;
            n_q    = '0;
            n_b    = i_b;
            n_bit  = 48'h1 << 46;
            if (i_req.op == OP_DIV) begin
                n_x   = {a_mag, 16'd0};
                n_cnt = 6'd47;
            end else begin
                n_x   = {i_a, 16'd0};
                n_cnt = 6'd23;
            end
        end else if (r_busy) begin
            unique case (r_op)
                OP_DIV: begin
                    n_x = {r_x[46:0], 1'b0};
                    if (rem_sh >= {1'b0, r_b}) begin
                        n_rem = rem_sh - {1'b0, r_b};
                        n_q   = {r_q[46:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_q   = {r_q[46:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    if (r_x >= trial) begin
                        n_x = r_x - trial;
                        n_q = (r_q >> 1) + r_bit;
                    end else begin
                        n_q = r_q >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            endcase
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_bit <= n_bit;
        r_b   <= n_b;
    end

    // sign and saturate the quotient magnitude; the root passes through unchanged
    always_comb begin
        if (r_op == OP_SQRT) begin
            o_result = r_q[31:0];
        end else if (!r_neg) begin
            o_result = (r_q[47:31] != '0) ? 32'h7fff_ffff : r_q[31:0];
        end else begin
            o_result = (r_q > 48'h0000_8000_0000) ? 32'h8000_0000 : (~r_q[31:0] + 32'd1);
        end
    end

    assign o_done = r_done;

endmodule

/* src/cholesky_decomposition_unit.sv */
// operation: an item without the last flag is written into the store; the last item starts
//   factoring, each entry (i,j) below the diagonal through the 48-step divider and each
//   diagonal entry through the 24-step root, then the entries of L are emitted in row order
// throughput: one item per cycle while loading, no items taken while factoring or emitting
// reset: synchronous active low; matrix size returns to 8, the store is not cleared
module cholesky_decomposition_unit import chol_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [IDX_W-1:0]    i_in_row,
    input  logic [IDX_W-1:0]    i_in_col,
    input  logic signed [31:0]  i_element_value,
    input  logic                i_last_element,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [IDX_W-1:0]    o_out_row,
    output logic [IDX_W-1:0]    o_out_col,
    output logic signed [31:0]  o_factor_value,
    output logic                o_not_positive_definite,
    output logic                o_last_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [31:0]        r_acc, n_acc, r_opa, n_opa;
    logic signed [63:0] r_prod, n_prod;

    logic               r_ovalid, n_ovalid;
    logic [IDX_W-1:0]   r_orow, n_orow, r_ocol, n_ocol;
    logic [31:0]        r_oval, n_oval;
    logic               r_obad, n_obad, r_olast, n_olast;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata, ram_rdata;

    t_unit_req          u_req;
    logic               u_done;
    logic [31:0]        u_result;

    logic [SIZE_W-1:0]  n_use;
    logic               in_xfer, slot_free, at_end;
    logic signed [47:0] prod_sh;
    logic [31:0]        prod_sat;
    logic signed [32:0] diff;
    logic [31:0]        diff_sat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MATRIX_SIZE) ? {28'd0, r_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MATRIX_SIZE) begin
            r_size <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        if (r_size == '0) begin
            n_use = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_SIZE)) begin
            n_use = SIZE_W'(MAX_SIZE);
        end else begin
            n_use = r_size;
        end
    end

    assign o_stall   = (r_state != S_LOAD);
    assign in_xfer   = i_valid && !o_stall;
    assign slot_free = !r_ovalid || !i_stall;
    assign at_end    = ({1'b0, r_i} == n_use - SIZE_W'(1)) && (r_j == r_i);

    // floored product, then saturated difference
    assign prod_sh  = 48'(r_prod >>> 16);
    assign prod_sat = (prod_sh > 48'sh0000_7fff_ffff) ? 32'h7fff_ffff :
                      (prod_sh < -48'sh0000_8000_0000) ? 32'h8000_0000 : prod_sh[31:0];
    assign diff     = $signed({r_acc[31], r_acc}) - $signed({prod_sat[31], prod_sat});
    assign diff_sat = (diff[32] != diff[31]) ? (diff[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                             : diff[31:0];

    always_comb begin
        unique case (r_state)
            S_KLOOP: ram_raddr = {r_i, r_k};
            S_KA:    ram_raddr = {r_j, r_k};
            S_FIN:   ram_raddr = {r_j, r_j};
            default: ram_raddr = {r_i, r_j};
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_acc    = r_acc;
        n_opa    = r_opa;
        n_prod   = r_prod;
        n_ovalid = r_ovalid && i_stall;
        n_orow   = r_orow;
        n_ocol   = r_ocol;
        n_oval   = r_oval;
        n_obad   = r_obad;
        n_olast  = r_olast;
        ram_we    = 1'b0;
        ram_waddr = {r_i, r_j};
        ram_wdata = u_result;
        u_req.start = 1'b0;
        u_req.op    = (r_j == r_i) ? OP_SQRT : OP_DIV;
        unique case (r_state)
            S_LOAD: begin
                ram_waddr = {i_in_row, i_in_col};
                ram_wdata = i_element_value;
                if (in_xfer) begin
                    ram_we = ({1'b0, i_in_row} < n_use) && (i_in_col <= i_in_row);
                    if (i_last_element) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: n_state = S_K0;
            S_K0: begin
                n_acc   = ram_rdata;
                n_k     = '0;
                n_state = S_KLOOP;
            end
            S_KLOOP: n_state = (r_k == r_j) ? S_FIN : S_KA;
            S_KA: begin
                n_opa   = ram_rdata;
                n_state = S_KB;
            end
            S_KB: begin
                n_prod  = $signed(r_opa) * $signed(ram_rdata);
                n_state = S_KSUB;
            end
            S_KSUB: begin
                n_acc   = diff_sat;
                n_k     = r_k + IDX_W'(1);
                n_state = S_KLOOP;
            end
            S_FIN: begin
                if (r_j != r_i) begin
                    n_state = S_DIVGO;
                end else if (r_acc[31] || r_acc == '0) begin
                    n_state = S_EERR;
                end else begin
                    u_req.start = 1'b1;
                    n_state     = S_WAITU;
                end
            end
            S_DIVGO: begin
                u_req.start = 1'b1;
                n_state     = S_WAITU;
            end
            S_WAITU: begin
                if (u_done) begin
                    ram_we = 1'b1;
                    if (at_end) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_ERD;
                    end else if (r_j == r_i) begin
                        n_i     = r_i + IDX_W'(1);
                        n_j     = '0;
                        n_state = S_ACC;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_ACC;
                    end
                end
            end
            S_ERD: n_state = S_EOUT;
            S_EOUT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = r_i;
                    n_ocol   = r_j;
                    n_oval   = ram_rdata;
                    n_obad   = 1'b0;
                    n_olast  = at_end;
                    if (at_end) begin
                        n_state = S_LOAD;
                    end else if (r_j == r_i) begin
                        n_i     = r_i + IDX_W'(1);
                        n_j     = '0;
                        n_state = S_ERD;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_ERD;
                    end
                end
            end
            S_EERR: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = r_i;
                    n_ocol   = r_i;
                    n_oval   = '0;
                    n_obad   = 1'b1;
                    n_olast  = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_opa   <= n_opa;
        r_prod  <= n_prod;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_oval  <= n_oval;
        r_obad  <= n_obad;
        r_olast <= n_olast;
    end

    chol_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    chol_divsqrt u_divsqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (u_req),
        .i_a      (r_acc),
        .i_b      (ram_rdata),
        .o_done   (u_done),
        .o_result (u_result)
    );

    assign o_valid                 = r_ovalid;
    assign o_out_row               = r_orow;
    assign o_out_col               = r_ocol;
    assign o_factor_value          = r_oval;
    assign o_not_positive_definite = r_obad;
    assign o_last_result           = r_olast;

    `include "cholesky_decomposition_unit_assert.svh"

    `CHOL_ASSERT_NOW(a_err_is_last, o_valid && o_not_positive_definite, o_last_result,
        "error transfer without last flag")
    `CHOL_ASSERT_NOW(a_unit_done_wait, u_done, r_state == S_WAITU,
        "arith unit finished outside of wait state")
    `CHOL_ASSERT_NOW(a_store_write, ram_we, r_state == S_LOAD || r_state == S_WAITU,
        "store written while reading operands")
    `CHOL_ASSERT_NEXT(a_last_start, in_xfer && i_last_element, r_state == S_ACC,
        "last element did not start factoring")

endmodule
